>>> sv/kme_pkg.sv
// shared types and constants for the morse keying encoder
`default_nettype none

package kme_pkg;

    localparam int CHAR_W      = 8;
    localparam int GAP_W       = 3;
    localparam int LEN_W       = 3;
    localparam int PAT_W       = 6;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [GAP_W-1:0] LETTER_GAP_RST = 3'd3;
    localparam logic [GAP_W-1:0] WORD_GAP_RST   = 3'd4;

    typedef enum logic [1:0] {
        K_CHAR  = 2'd0,
        K_SPACE = 2'd1,
        K_UNSUP = 2'd2
    } t_kind;

    // element pattern is left aligned, first element in the top bit, 1 = dash
    typedef struct packed {
        t_kind            kind;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
    } t_desc;

endpackage

`default_nettype wire

>>> sv/kme_front.sv
// front end: case folding and table lookup of one character per transfer
`default_nettype none

module kme_front
    import kme_pkg::*;
(
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire logic              i_valid,
    output logic                   o_push,
    output t_desc                  o_desc
);

    function automatic t_desc classify(input logic [CHAR_W-1:0] code);
        t_desc            d;
        logic [CHAR_W-1:0] c;
        c = code;
        if (code >= "a" && code <= "z") begin
            c = code - 8'd32;
        end
        d.kind = K_CHAR;
        d.len  = 3'd0;
        d.pat  = 6'b000000;
        unique case (c)
            "A": begin d.len = 3'd2; d.pat = 6'b010000; end
            "B": begin d.len = 3'd4; d.pat = 6'b100000; end
            "C": begin d.len = 3'd4; d.pat = 6'b101000; end
            "D": begin d.len = 3'd3; d.pat = 6'b100000; end
            "E": begin d.len = 3'd1; d.pat = 6'b000000; end
            "F": begin d.len = 3'd4; d.pat = 6'b001000; end
            "G": begin d.len = 3'd3; d.pat = 6'b110000; end
            "H": begin d.len = 3'd4; d.pat = 6'b000000; end
            "I": begin d.len = 3'd2; d.pat = 6'b000000; end
            "J": begin d.len = 3'd4; d.pat = 6'b011100; end
            "K": begin d.len = 3'd3; d.pat = 6'b101000; end
            "L": begin d.len = 3'd4; d.pat = 6'b010000; end
            "M": begin d.len = 3'd2; d.pat = 6'b110000; end
            "N": begin d.len = 3'd2; d.pat = 6'b100000; end
            "O": begin d.len = 3'd3; d.pat = 6'b111000; end
            "P": begin d.len = 3'd4; d.pat = 6'b011000; end
            "Q": begin d.len = 3'd4; d.pat = 6'b110100; end
            "R": begin d.len = 3'd3; d.pat = 6'b010000; end
            "S": begin d.len = 3'd3; d.pat = 6'b000000; end
            "T": begin d.len = 3'd1; d.pat = 6'b100000; end
            "U": begin d.len = 3'd3; d.pat = 6'b001000; end
            "V": begin d.len = 3'd4; d.pat = 6'b000100; end
            "W": begin d.len = 3'd3; d.pat = 6'b011000; end
            "X": begin d.len = 3'd4; d.pat = 6'b100100; end
            "Y": begin d.len = 3'd4; d.pat = 6'b101100; end
            "Z": begin d.len = 3'd4; d.pat = 6'b110000; end
            "0": begin d.len = 3'd5; d.pat = 6'b111110; end
            "1": begin d.len = 3'd5; d.pat = 6'b011110; end
            "2": begin d.len = 3'd5; d.pat = 6'b001110; end
            "3": begin d.len = 3'd5; d.pat = 6'b000110; end
            "4": begin d.len = 3'd5; d.pat = 6'b000010; end
            "5": begin d.len = 3'd5; d.pat = 6'b000000; end
            "6": begin d.len = 3'd5; d.pat = 6'b100000; end
            "7": begin d.len = 3'd5; d.pat = 6'b110000; end
            "8": begin d.len = 3'd5; d.pat = 6'b111000; end
            "9": begin d.len = 3'd5; d.pat = 6'b111100; end
            ".": begin d.len = 3'd6; d.pat = 6'b010101; end
            ",": begin d.len = 3'd6; d.pat = 6'b110011; end
            "?": begin d.len = 3'd6; d.pat = 6'b001100; end
            "'": begin d.len = 3'd6; d.pat = 6'b011110; end
            "!": begin d.len = 3'd6; d.pat = 6'b101011; end
            "/": begin d.len = 3'd5; d.pat = 6'b100100; end
            "(": begin d.len = 3'd5; d.pat = 6'b101100; end
            ")": begin d.len = 3'd6; d.pat = 6'b101101; end
            "&": begin d.len = 3'd5; d.pat = 6'b010000; end
            ":": begin d.len = 3'd6; d.pat = 6'b111000; end
            ";": begin d.len = 3'd6; d.pat = 6'b101010; end
            "=": begin d.len = 3'd5; d.pat = 6'b100010; end
            "+": begin d.len = 3'd5; d.pat = 6'b010100; end
            "-": begin d.len = 3'd6; d.pat = 6'b100001; end
            "_": begin d.len = 3'd6; d.pat = 6'b001101; end
            " ": begin d.kind = K_SPACE; end
            default: begin d.kind = K_UNSUP; end
        endcase
        return d;
    endfunction

    assign o_push = i_valid;
    assign o_desc = classify(i_char_code);

endmodule

`default_nettype wire

>>> sv/kme_queue.sv
// short descriptor queue between the front end and the keying sequencer
`default_nettype none

module kme_queue
    import kme_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_desc,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_desc      o_desc
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_desc          r_mem [DEPTH];
    logic [PW-1:0]  r_wptr, n_wptr;
    logic [PW-1:0]  r_rptr, n_rptr;
    logic [CW-1:0]  r_count, n_count;
    logic           wr_en;
    logic           rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr_en) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (rd_en) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CW'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

endmodule

`default_nettype wire

>>> sv/kme_back.sv
// keying sequencer: one unit per cycle into an output register while the output is not stalled
`default_nettype none

module kme_back
    import kme_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [GAP_W-1:0] i_letter_gap,
    input  wire logic [GAP_W-1:0] i_word_gap,
    input  wire logic             i_q_valid,
    input  wire t_desc            i_q_desc,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic                  o_key_on,
    output logic                  o_last_unit,
    output logic                  o_unsupported
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ON   = 5'b00010,
        S_SEP  = 5'b00100,
        S_GAP  = 5'b01000,
        S_UNS  = 5'b10000
    } t_state;

    t_state           r_state, n_state, cur_state;
    logic [GAP_W-1:0] r_cnt, n_cnt, cur_cnt;
    logic [LEN_W-1:0] r_left, n_left, cur_left;
    logic [PAT_W-1:0] r_pat, n_pat, cur_pat;
    logic             r_valid;
    logic             r_key_on, r_last_unit, r_unsupported;
    logic             adv;
    logic             emit;
    logic [GAP_W-1:0] lgap, wgap;

    assign lgap = (i_letter_gap == '0) ? GAP_W'(1) : i_letter_gap;
    assign wgap = (i_word_gap == '0) ? GAP_W'(1) : i_word_gap;
    assign adv  = !r_valid || !i_stall;

    // current unit comes from the running character or straight from the queue head
    always_comb begin
        cur_state = r_state;
        cur_cnt   = r_cnt;
        cur_left  = r_left;
        cur_pat   = r_pat;
        o_pop     = 1'b0;
        if (r_state == S_IDLE && i_q_valid) begin
            o_pop    = adv;
            cur_left = i_q_desc.len;
            cur_pat  = i_q_desc.pat;
            unique case (i_q_desc.kind)
                K_CHAR: begin
                    cur_state = S_ON;
                    cur_cnt   = i_q_desc.pat[PAT_W-1] ? GAP_W'(3) : GAP_W'(1);
                end
                K_SPACE: begin
                    cur_state = S_GAP;
                    cur_cnt   = wgap;
                end
                default: begin
                    cur_state = S_UNS;
                    cur_cnt   = GAP_W'(1);
                end
            endcase
        end
    end

    assign emit = (cur_state != S_IDLE);

    always_comb begin
        n_state = cur_state;
        n_cnt   = cur_cnt - GAP_W'(1);
        n_left  = cur_left;
        n_pat   = cur_pat;
        if (cur_cnt <= GAP_W'(1)) begin
            unique case (cur_state)
                S_ON: begin
                    if (cur_left <= LEN_W'(1)) begin
                        n_state = S_GAP;
                        n_cnt   = lgap;
                    end else begin
                        n_state = S_SEP;
                        n_cnt   = GAP_W'(1);
                    end
                end
                S_SEP: begin
                    n_state = S_ON;
                    n_pat   = cur_pat << 1;
                    n_left  = cur_left - LEN_W'(1);
                    n_cnt   = cur_pat[PAT_W-2] ? GAP_W'(3) : GAP_W'(1);
                end
                S_GAP, S_UNS: begin
                    n_state = S_IDLE;
                end
                default: begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else if (adv) begin
            r_state <= n_state;
            r_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cnt         <= n_cnt;
            r_left        <= n_left;
            r_pat         <= n_pat;
            r_key_on      <= (cur_state == S_ON);
            r_last_unit   <= (cur_state == S_UNS)
                             || (cur_state == S_GAP && cur_cnt == GAP_W'(1));
            r_unsupported <= (cur_state == S_UNS);
        end
    end

    assign o_valid       = r_valid;
    assign o_key_on      = r_key_on;
    assign o_last_unit   = r_last_unit;
    assign o_unsupported = r_unsupported;

endmodule

`default_nettype wire

>>> sv/morse_keying_encoder.sv
// top level of the morse keying encoder with its register port
`default_nettype none

// Takes one ASCII character per input transfer and gives its Morse keying as
// one output transfer per time unit (key on or off), with the last unit of each
// character marked. A letter gives its element units plus letter_gap_units off
// units, a space gives word_gap_units off units, any other code gives one
// flagged unit; a gap register of zero acts as one. The keying sequencer gives
// one unit per cycle while the output is not stalled, and the input side takes
// a new character while the descriptor queue (QUEUE_DEPTH entries) has room, so
// input and output stall independently.
// Registers: letter gap at byte address 0, word gap at byte address 4.
module morse_keying_encoder
    import kme_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [CHAR_W-1:0] i_char_code,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_key_on,
    output logic                   o_last_unit,
    output logic                   o_unsupported,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam logic REG_LETTER_GAP = 1'b0;
    localparam logic REG_WORD_GAP   = 1'b1;

    logic [GAP_W-1:0] r_letter_gap;
    logic [GAP_W-1:0] r_word_gap;
    logic             cfg_wr;
    logic             push;
    t_desc            front_desc;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    t_desc            q_desc;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_letter_gap <= LETTER_GAP_RST;
            r_word_gap   <= WORD_GAP_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_LETTER_GAP: r_letter_gap <= pwdata[GAP_W-1:0];
                REG_WORD_GAP:   r_word_gap   <= pwdata[GAP_W-1:0];
                default:        r_word_gap   <= r_word_gap;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LETTER_GAP: prdata = APB_DW'(r_letter_gap);
            REG_WORD_GAP:   prdata = APB_DW'(r_word_gap);
            default:        prdata = '0;
        endcase
    end

    assign o_stall = q_full;

    kme_front u_front (
        .i_char_code (i_char_code),
        .i_valid     (i_valid),
        .o_push      (push),
        .o_desc      (front_desc)
    );

    kme_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (front_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    kme_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_letter_gap  (r_letter_gap),
        .i_word_gap    (r_word_gap),
        .i_q_valid     (q_valid),
        .i_q_desc      (q_desc),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_key_on      (o_key_on),
        .o_last_unit   (o_last_unit),
        .o_unsupported (o_unsupported)
    );

endmodule

`default_nettype wire
